FILE: design/sliding_window_fetch_tracker_top_defines.svh
// Assertion macros shared by the fetch tracker RTL.
// Needs a clock named clk and an active-high reset named rst in the module that uses them.
`ifndef SLIDING_WINDOW_FETCH_TRACKER_TOP_DEFINES_SVH
`define SLIDING_WINDOW_FETCH_TRACKER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWFT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SWFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/swft_pkg.sv
// Shared types, constants and helpers for the sliding window fetch tracker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package swft_pkg;

  localparam int WINDOW = 16;
  localparam int SLOT_W = $clog2(WINDOW);
  localparam int CNT_W = $clog2(WINDOW + 1);

  localparam int LEN_W = 16;
  localparam int SIZE_W = 32;
  localparam int TMR_W = 20;
  localparam int OFF_W = SIZE_W + 1;
  localparam int AHEAD_W = OFF_W + 1;

  localparam logic [LEN_W-1:0] SEG_LEN_RST = LEN_W'(1000);
  localparam logic [TMR_W-1:0] RETRY_RST = TMR_W'(100000);

  localparam logic [1:0] KIND_REQUEST = 2'd0;
  localparam logic [1:0] KIND_DELIVER = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_ARRIVAL = 1'b1;

  localparam logic [1:0] CFG_SEG_LEN = 2'd0;
  localparam logic [1:0] CFG_TOTAL_SIZE = 2'd1;
  localparam logic [1:0] CFG_RETRY = 2'd2;

  typedef struct packed {
    logic [SLOT_W-1:0] idx;
    logic set_flag;
    logic clr_flag;
    logic wr_timer;
    logic [TMR_W-1:0] timer_val;
  } slot_cmd_t;

  // Circular slot index: base plus a distance of at most WINDOW, wrapped once.
  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
    logic [SLOT_W:0] sum;
    sum = {1'b0, a} + (SLOT_W + 1)'(b);
    if (sum >= (SLOT_W + 1)'(WINDOW)) begin
      sum = sum - (SLOT_W + 1)'(WINDOW);
    end
    return sum[SLOT_W-1:0];
  endfunction

endpackage

FILE: design/swft_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on swft_pkg for the field widths.
`timescale 1ns / 1ps

module swft_div
  import swft_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [SIZE_W-1:0] dividend,
  input  logic [LEN_W-1:0]  divisor,
  output logic              done,
  output logic [SIZE_W-1:0] quotient
);

  localparam int STEP_W = $clog2(SIZE_W + 1);

  logic              running;
  logic [STEP_W-1:0] steps;
  logic [LEN_W-1:0]  rem;
  logic [LEN_W-1:0]  dsr;
  logic [SIZE_W-1:0] quo;

  logic [LEN_W:0]   rem_sh;
  logic [LEN_W+1:0] trial;

  always_comb begin
    rem_sh = {rem, quo[SIZE_W-1]};
    trial = {1'b0, rem_sh} - {2'b00, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      steps <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        steps <= STEP_W'(SIZE_W);
      end else if (running) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem <= '0;
      dsr <= divisor;
      quo <= dividend;
    end else if (running) begin
      if (!trial[LEN_W+1]) begin
        rem <= trial[LEN_W-1:0];
        quo <= {quo[SIZE_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[LEN_W-1:0];
        quo <= {quo[SIZE_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = quo;

endmodule

FILE: design/swft_slots.sv
// Per-slot received flags and retry timers of the window.
// Depends on swft_pkg for the slot command structure.
`timescale 1ns / 1ps

module swft_slots
  import swft_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  slot_cmd_t        cmd,
  output logic             rd_flag,
  output logic [TMR_W-1:0] rd_timer
);

  logic             flags [WINDOW];
  logic [TMR_W-1:0] timers [WINDOW];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < WINDOW; k++) begin
        flags[k] <= 1'b0;
        timers[k] <= '0;
      end
    end else begin
      if (cmd.set_flag) begin
        flags[cmd.idx] <= 1'b1;
      end else if (cmd.clr_flag) begin
        flags[cmd.idx] <= 1'b0;
      end
      if (cmd.wr_timer) begin
        timers[cmd.idx] <= cmd.timer_val;
      end
    end
  end

  assign rd_flag = flags[cmd.idx];
  assign rd_timer = timers[cmd.idx];

endmodule

FILE: design/sliding_window_fetch_tracker_top.sv
// Tick: the timer pass (S_P1) visits each window slot (up to WINDOW+1), then S_P2_DLV takes
// each delivered slot and S_P2_REQ each request ahead, S_P2_DLV closes the delivery pass and
// S_STATUS sends the status word. The first word leaves the result register after S_P1 is entered.
// Arrival: S_DIV waits for the 32-step divider's base segment, S_ARR marks an in-window slot.
// One item at a time: busy stays high until the status word is out. Results cannot be stalled.
// rst is synchronous: window, flags and timers clear and configuration returns to defaults.
`timescale 1ns / 1ps
`include "sliding_window_fetch_tracker_top_defines.svh"

module sliding_window_fetch_tracker_top
  import swft_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // Item command channel.
  input  logic              start,
  output logic              busy,
  input  logic              action,
  input  logic [TMR_W-1:0]  elapsed_usec,
  input  logic [SIZE_W-1:0] arrived_segment,
  // Result words, one per strobe cycle.
  output logic              strobe,
  output logic [1:0]        kind,
  output logic [SIZE_W-1:0] offset,
  output logic [SIZE_W-1:0] window_base,
  output logic              last,
  // Configuration write channel.
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [SIZE_W-1:0] cfg_data
);

  // The timer pass (S_P1) walks the window one slot per cycle. It also finds
  // the run of received slots at the window head, so the final window base is
  // known by the time the first request leaves, which every word must carry.
  typedef enum logic [2:0] {
    S_IDLE,
    S_P1,
    S_P2_DLV,
    S_P2_REQ,
    S_DIV,
    S_ARR,
    S_STATUS
  } state_t;

  state_t state;

  // Configuration registers.
  logic [LEN_W-1:0]  seg_len_cfg;
  logic [SIZE_W-1:0] total_size_cfg;
  logic [TMR_W-1:0]  retry_cfg;

  // Window state.
  logic [SIZE_W-1:0] base_offset;
  logic [SLOT_W-1:0] base_slot;

  // Working registers of the sequencer.
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  deliv_cnt;
  logic [OFF_W-1:0]  acc;
  logic              scanning;
  logic [SIZE_W-1:0] final_base;
  logic [TMR_W-1:0]  elapsed;
  logic [SIZE_W-1:0] arr_seg;
  logic [SIZE_W+LEN_W-1:0] prod;
  logic [SIZE_W-1:0] ahead;

  // Divider and slot store.
  logic              div_go;
  logic              div_done;
  logic [SIZE_W-1:0] div_quo;
  slot_cmd_t         cmd;
  logic              rd_flag;
  logic [TMR_W-1:0]  rd_timer;

  // Combinational helpers.
  logic [LEN_W-1:0]   eff_len;
  logic [SLOT_W-1:0]  cur_slot;
  logic [SLOT_W-1:0]  arr_slot;
  logic               out_of_range;
  logic               end1;
  logic               stop_scan;
  logic [SIZE_W-1:0]  sat_off;
  logic [SIZE_W-1:0]  win_now;
  logic [TMR_W:0]     tdiff;
  logic               expired;
  logic [AHEAD_W-1:0] ahead_sum;
  logic               ahead_ok;
  logic [SIZE_W:0]    rel;
  logic               in_win;
  logic               accept;

  assign accept = start && !busy;
  assign busy = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    // A segment length of zero behaves as one byte.
    eff_len = (seg_len_cfg == '0) ? LEN_W'(1) : seg_len_cfg;
    cur_slot = slot_add(base_slot, cnt);

    // The running offset acc is base plus cnt segments.
    out_of_range = (acc >= {1'b0, total_size_cfg});
    end1 = (cnt == CNT_W'(WINDOW)) || out_of_range;
    stop_scan = end1 || !rd_flag;
    sat_off = acc[SIZE_W] ? '1 : acc[SIZE_W-1:0];
    win_now = scanning ? sat_off : final_base;

    // The single compare-and-subtract used for timer expiry.
    tdiff = {1'b0, rd_timer} - {1'b0, elapsed};
    expired = tdiff[TMR_W] || (tdiff[TMR_W-1:0] == '0);

    ahead_sum = AHEAD_W'(acc) + AHEAD_W'(eff_len) * AHEAD_W'(WINDOW);
    ahead_ok = (ahead_sum < AHEAD_W'(total_size_cfg));

    // Arrival: distance of the segment from the base segment number.
    rel = {1'b0, arr_seg} - {1'b0, div_quo};
    in_win = !rel[SIZE_W] && (rel[SIZE_W-1:0] < SIZE_W'(WINDOW))
             && (prod < (SIZE_W + LEN_W)'(total_size_cfg));
    arr_slot = slot_add(base_slot, CNT_W'(rel[SLOT_W-1:0]));

    div_go = accept && (action == ACT_ARRIVAL);
  end

  always_comb begin
    cmd = '0;
    cmd.idx = cur_slot;
    unique case (state)
      S_P1: begin
        if (!end1 && !rd_flag) begin
          cmd.wr_timer = 1'b1;
          cmd.timer_val = expired ? retry_cfg : tdiff[TMR_W-1:0];
        end
      end
      S_P2_REQ: begin
        cmd.clr_flag = 1'b1;
        cmd.wr_timer = 1'b1;
        cmd.timer_val = retry_cfg;
      end
      S_ARR: begin
        cmd.idx = arr_slot;
        cmd.set_flag = in_win;
      end
      default: begin
        cmd.idx = cur_slot;
      end
    endcase
  end

  swft_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (base_offset),
    .divisor  (eff_len),
    .done     (div_done),
    .quotient (div_quo)
  );

  swft_slots u_slots (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .rd_flag  (rd_flag),
    .rd_timer (rd_timer)
  );

  // Configuration is taken whenever offered; the user sends writes only while idle (not enforced).
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_len_cfg <= SEG_LEN_RST;
      total_size_cfg <= '0;
      retry_cfg <= RETRY_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SEG_LEN:    seg_len_cfg <= cfg_data[LEN_W-1:0];
        CFG_TOTAL_SIZE: total_size_cfg <= cfg_data;
        CFG_RETRY:      retry_cfg <= cfg_data[TMR_W-1:0];
        default:        ;
      endcase
    end
  end

  // Sequencer, window state and registered result word.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      base_offset <= '0;
      base_slot <= '0;
      strobe <= 1'b0;
      last <= 1'b0;
      scanning <= 1'b0;
      cnt <= '0;
      deliv_cnt <= '0;
    end else begin
      strobe <= 1'b0;
      last <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            elapsed <= elapsed_usec;
            arr_seg <= arrived_segment;
            final_base <= base_offset;
            deliv_cnt <= '0;
            cnt <= '0;
            acc <= {1'b0, base_offset};
            scanning <= 1'b1;
            state <= (action == ACT_TICK) ? S_P1 : S_DIV;
          end
        end
        S_P1: begin
          // The first slot that is unreceived or past the end fixes the new base.
          if (scanning && stop_scan) begin
            scanning <= 1'b0;
            deliv_cnt <= cnt;
            final_base <= sat_off;
          end
          if (end1) begin
            cnt <= '0;
            acc <= {1'b0, base_offset};
            state <= S_P2_DLV;
          end else begin
            if (!rd_flag && expired) begin
              strobe <= 1'b1;
              kind <= KIND_REQUEST;
              offset <= acc[SIZE_W-1:0];
              window_base <= win_now;
            end
            cnt <= cnt + CNT_W'(1);
            acc <= acc + OFF_W'(eff_len);
          end
        end
        S_P2_DLV: begin
          if (cnt == deliv_cnt) begin
            state <= S_STATUS;
          end else begin
            strobe <= 1'b1;
            kind <= KIND_DELIVER;
            offset <= acc[SIZE_W-1:0];
            window_base <= final_base;
            ahead <= ahead_sum[SIZE_W-1:0];
            if (ahead_ok) begin
              state <= S_P2_REQ;
            end else begin
              cnt <= cnt + CNT_W'(1);
              acc <= acc + OFF_W'(eff_len);
            end
          end
        end
        S_P2_REQ: begin
          // The slot is reused for the segment one window further on.
          strobe <= 1'b1;
          kind <= KIND_REQUEST;
          offset <= ahead;
          window_base <= final_base;
          cnt <= cnt + CNT_W'(1);
          acc <= acc + OFF_W'(eff_len);
          state <= S_P2_DLV;
        end
        S_DIV: begin
          prod <= (SIZE_W + LEN_W)'(arr_seg) * (SIZE_W + LEN_W)'(eff_len);
          if (div_done) begin
            state <= S_ARR;
          end
        end
        S_ARR: begin
          state <= S_STATUS;
        end
        S_STATUS: begin
          strobe <= 1'b1;
          last <= 1'b1;
          kind <= KIND_STATUS;
          offset <= '0;
          window_base <= final_base;
          base_offset <= final_base;
          base_slot <= slot_add(base_slot, deliv_cnt);
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SWFT_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted item did not raise busy")
  `SWFT_ASSERT_SAME(a_status_form, strobe && (kind == KIND_STATUS), last && (offset == '0), "status word malformed")
  `SWFT_ASSERT_NEXT(a_last_gap, strobe && last, !strobe, "word followed the status word")
  `SWFT_ASSERT_SAME(a_idle_words, !busy && strobe, last, "non-final word while idle")

endmodule

FILE: tb/tb.sv
// Self-checking testbench for sliding_window_fetch_tracker_top: directed and random
// ticks and arrivals, every result word checked against a built-in window model.
// Depends on swft_pkg and the tracker RTL only.
`timescale 1ns / 1ps

module tb
  import swft_pkg::*;
();

  // Index 3 maps to no register; a write there must leave every setting alone.
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned MAX_ELAPSED = 1000000;
  // The longest sender gap and the longest tick both fall well short of this.
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 60;
  localparam int PHASE_ITEMS = 47;

  typedef struct packed {
    logic [1:0]        kind;
    logic [SIZE_W-1:0] offset;
    logic [SIZE_W-1:0] window_base;
    logic              last;
  } result_word_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic              action = ACT_TICK;
  logic [TMR_W-1:0]  elapsed_usec = '0;
  logic [SIZE_W-1:0] arrived_segment = '0;
  logic              strobe;
  logic [1:0]        kind;
  logic [SIZE_W-1:0] offset;
  logic [SIZE_W-1:0] window_base;
  logic              last;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = CFG_SEG_LEN;
  logic [SIZE_W-1:0] cfg_data = '0;

  // Our own copy of the settings and of the window, kept in step with the block.
  logic [LEN_W-1:0]  seg_len_reg;
  logic [SIZE_W-1:0] obj_size_reg;
  logic [TMR_W-1:0]  retry_reg;
  logic [SIZE_W-1:0] base_off;
  logic [SLOT_W-1:0] base_idx;
  logic              got [WINDOW];
  logic [TMR_W-1:0]  timers [WINDOW];

  result_word_t      pending_words[$];
  int                errors = 0;
  int                idle_cycles = 0;
  bit                gapless = 1'b0;

  sliding_window_fetch_tracker_top DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .action(action),
    .elapsed_usec(elapsed_usec),
    .arrived_segment(arrived_segment),
    .strobe(strobe),
    .kind(kind),
    .offset(offset),
    .window_base(window_base),
    .last(last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A segment length of zero behaves as one byte.
  function automatic longint unsigned eff_len();
    return (seg_len_reg == '0) ? 64'd1 : 64'(seg_len_reg);
  endfunction

  function automatic longint unsigned base_segment();
    return 64'(base_off) / eff_len();
  endfunction

  function automatic void window_reset();
    int i;
    seg_len_reg = SEG_LEN_RST;
    obj_size_reg = '0;
    retry_reg = RETRY_RST;
    base_off = '0;
    base_idx = '0;
    for (i = 0; i < WINDOW; i++) begin
      got[i] = 1'b0;
      timers[i] = '0;
    end
  endfunction

  // Moves the window model on by one input word and queues the result words it
  // causes.
  function automatic void predict_item(input logic act, input logic [TMR_W-1:0] elapsed,
                                       input logic [SIZE_W-1:0] seg);
    longint unsigned len;
    longint unsigned size;
    longint unsigned off;
    longint unsigned ahead;
    longint unsigned rel;
    longint unsigned nbase;
    logic [1:0]        kinds[$];
    logic [SIZE_W-1:0] offs[$];
    logic [SLOT_W-1:0] s;
    result_word_t      w;
    int                i;
    len = eff_len();
    size = 64'(obj_size_reg);
    if (act == ACT_TICK) begin
      // Timer pass over every position that still lies inside the object.
      for (i = 0; i < WINDOW; i++) begin
        off = 64'(base_off) + 64'(i) * len;
        s = base_idx + SLOT_W'(i);
        if (off >= size) break;
        if (!got[s]) begin
          if (elapsed >= timers[s]) begin
            timers[s] = retry_reg;
            kinds.push_back(KIND_REQUEST);
            offs.push_back(SIZE_W'(off));
          end else begin
            timers[s] = timers[s] - elapsed;
          end
        end
      end
      // Delivery pass: the base slides over received slots in order.
      for (i = 0; i < WINDOW; i++) begin
        off = 64'(base_off) + 64'(i) * len;
        s = base_idx + SLOT_W'(i);
        if (off >= size || !got[s]) break;
        kinds.push_back(KIND_DELIVER);
        offs.push_back(SIZE_W'(off));
        ahead = off + len * 64'(WINDOW);
        if (ahead < size) begin
          got[s] = 1'b0;
          timers[s] = retry_reg;
          kinds.push_back(KIND_REQUEST);
          offs.push_back(SIZE_W'(ahead));
        end
      end
      nbase = 64'(base_off) + 64'(i) * len;
      base_off = (nbase > 64'hFFFF_FFFF) ? '1 : SIZE_W'(nbase);
      base_idx = base_idx + SLOT_W'(i);
    end else begin
      // Arrivals before the window, beyond it or past the object are ignored.
      if (64'(seg) >= base_segment()) begin
        rel = 64'(seg) - base_segment();
        if (rel < 64'(WINDOW) && 64'(seg) * len < size) begin
          got[base_idx + SLOT_W'(rel)] = 1'b1;
        end
      end
    end
    // Every word carries the base as it stands after the item; status comes last.
    kinds.push_back(KIND_STATUS);
    offs.push_back('0);
    for (i = 0; i < kinds.size(); i++) begin
      w.kind = kinds[i];
      w.offset = offs[i];
      w.window_base = base_off;
      w.last = (i == kinds.size() - 1);
      pending_words.push_back(w);
    end
  endfunction

  // Mostly short gaps, now and then a long one; none at all while gapless is set.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (gapless || r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Presents one input word on the command channel and holds it until the block takes it.
  // start is left high afterwards so that a following word can go out back to back.
  task automatic send_item(input logic act, input logic [TMR_W-1:0] elapsed,
                           input logic [SIZE_W-1:0] seg);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start = 1'b1;
    action = act;
    elapsed_usec = elapsed;
    arrived_segment = seg;
    do @(posedge clk); while (busy);
    predict_item(act, elapsed, seg);
  endtask

  // Lowers start and waits until every expected word is out and the block is quiet.
  task automatic wait_idle();
    @(negedge clk);
    start = 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [SIZE_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SEG_LEN:    seg_len_reg = data[LEN_W-1:0];
      CFG_TOTAL_SIZE: obj_size_reg = data;
      CFG_RETRY:      retry_reg = data[TMR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Reset settings leave an empty object, so a tick yields the status word alone.
  task automatic test_empty_object();
    send_item(ACT_TICK, TMR_W'(MAX_ELAPSED), '0);
    send_item(ACT_ARRIVAL, '0, '0);
    send_item(ACT_TICK, '0, '1);
  endtask

  // A twenty-byte object in one-byte segments (written as a zero length) walks the
  // window to the end of the object: first-tick requests, timers that expire at
  // equality, arrivals before, beyond and past the end of the window, and the last
  // deliveries that keep their flag because nothing lies one window ahead.
  task automatic test_short_object();
    wait_idle();
    write_reg(CFG_SEG_LEN, '0);
    write_reg(CFG_TOTAL_SIZE, 32'd20);
    write_reg(CFG_RETRY, 32'd1);
    write_reg(CFG_UNUSED, '1);
    send_item(ACT_TICK, '0, '0);
    send_item(ACT_ARRIVAL, '0, 32'd0);
    send_item(ACT_ARRIVAL, '0, 32'd2);
    send_item(ACT_ARRIVAL, '0, 32'd16);
    send_item(ACT_ARRIVAL, '0, '1);
    send_item(ACT_TICK, '0, '0);
    send_item(ACT_ARRIVAL, '0, 32'd1);
    send_item(ACT_TICK, TMR_W'(1), '0);
    send_item(ACT_ARRIVAL, '0, 32'd0);
    send_item(ACT_ARRIVAL, '0, 32'd3);
    send_item(ACT_ARRIVAL, '0, 32'd4);
    send_item(ACT_ARRIVAL, '0, 32'd5);
    send_item(ACT_TICK, TMR_W'(MAX_ELAPSED), '0);
    send_item(ACT_ARRIVAL, '0, 32'd20);
    send_item(ACT_ARRIVAL, '0, 32'd19);
    send_item(ACT_TICK, '0, '0);
  endtask

  // Largest segment, largest object and longest retry time.
  task automatic test_extremes();
    wait_idle();
    write_reg(CFG_SEG_LEN, 32'hFFFF_FFFF);
    write_reg(CFG_TOTAL_SIZE, 32'hFFFF_FFFF);
    write_reg(CFG_RETRY, 32'(MAX_ELAPSED));
    send_item(ACT_TICK, TMR_W'(MAX_ELAPSED), '0);
    send_item(ACT_ARRIVAL, '0, 32'(base_segment()));
    send_item(ACT_ARRIVAL, '0, 32'(base_segment() + 15));
    send_item(ACT_ARRIVAL, '0, 32'(base_segment() + 16));
    send_item(ACT_TICK, '0, '0);
    send_item(ACT_TICK, TMR_W'(MAX_ELAPSED - 1), '0);
    send_item(ACT_ARRIVAL, '0, '1);
  endtask

  // Picks the settings for one random phase. The object is sized from the current
  // base so that the window has real work to do; junk above each field's width
  // checks that only the low bits are taken.
  task automatic configure_phase(input int phase);
    logic [LEN_W-1:0]  seg;
    logic [TMR_W-1:0]  retry;
    longint unsigned   len;
    longint unsigned   size;
    case (phase)
      0: begin
        seg = LEN_W'($urandom_range(1, 64));
        retry = TMR_W'($urandom_range(10, 300));
      end
      1: begin
        seg = '1;
        retry = TMR_W'(1);
      end
      2: begin
        seg = LEN_W'(1);
        retry = TMR_W'(MAX_ELAPSED);
      end
      default: begin
        seg = ($urandom_range(0, 3) == 0) ? LEN_W'($urandom_range(0, 8)) : LEN_W'($urandom);
        retry = TMR_W'($urandom_range(1, 2000));
      end
    endcase
    write_reg(CFG_SEG_LEN, {LEN_W'($urandom), seg});
    write_reg(CFG_RETRY, {12'($urandom), retry});
    len = eff_len();
    size = 64'(base_off) + 64'($urandom_range(0, 48)) * len
           + 64'($urandom_range(0, 32'(len - 1)));
    if (phase == 1 || size > 64'hFFFF_FFFF) size = 64'hFFFF_FFFF;
    write_reg(CFG_TOTAL_SIZE, SIZE_W'(size));
  endtask

  // Mostly arrivals inside the window so that the base keeps sliding, with ticks
  // whose elapsed time is matched to the retry time, plus some stray arrivals.
  task automatic random_item();
    int              r;
    int unsigned     span;
    longint unsigned bs;
    logic [SIZE_W-1:0] seg;
    logic [TMR_W-1:0]  el;
    r = $urandom_range(0, 99);
    if (r < 42) begin
      r = $urandom_range(0, 99);
      span = 2 * int'(retry_reg);
      if (span > MAX_ELAPSED) span = MAX_ELAPSED;
      if (r < 50) el = TMR_W'($urandom_range(0, span));
      else if (r < 75) el = TMR_W'($urandom_range(0, 20));
      else if (r < 85) el = '0;
      else if (r < 93) el = TMR_W'(MAX_ELAPSED);
      else el = TMR_W'($urandom_range(0, MAX_ELAPSED));
      send_item(ACT_TICK, el, SIZE_W'($urandom));
    end else begin
      bs = base_segment();
      r = $urandom_range(0, 99);
      if (r < 75) seg = SIZE_W'(bs + 64'($urandom_range(0, WINDOW - 1)));
      else if (r < 85) seg = SIZE_W'(bs + 64'(WINDOW) + 64'($urandom_range(0, 3)));
      else if (r < 93) seg = SIZE_W'(bs - 64'($urandom_range(1, 3)));
      else seg = SIZE_W'($urandom);
      send_item(ACT_ARRIVAL, TMR_W'($urandom), seg);
    end
  endtask

  // Several phases, each with fresh settings written while the block is quiet and
  // a fixed share of random words.
  task automatic test_random_fetch();
    int phase;
    for (phase = 0; phase < 6; phase++) begin
      wait_idle();
      configure_phase(phase);
      gapless = (phase == 2);
      repeat (PHASE_ITEMS) random_item();
    end
    gapless = 1'b0;
  endtask

  // Every strobe is one result word and must match the oldest expectation.
  always @(posedge clk) begin : result_check
    result_word_t want;
    if (!rst && strobe) begin
      if (pending_words.size() == 0) begin
        $error("unexpected result word: kind %0d offset %0d", kind, offset);
        errors++;
      end else begin
        want = pending_words.pop_front();
        if (kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, kind);
          errors++;
        end
        if (offset !== want.offset) begin
          $error("offset: expected %0d, actual %0d", want.offset, offset);
          errors++;
        end
        if (window_base !== want.window_base) begin
          $error("window_base: expected %0d, actual %0d", want.window_base, window_base);
          errors++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, last);
          errors++;
        end
      end
    end
  end

  // Watchdog: any accepted word on any channel restarts the count.
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("sliding_window_fetch_tracker_top verification failed");
      $finish;
    end
  end

  initial begin
    window_reset();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_empty_object();
    test_short_object();
    test_extremes();
    test_random_fetch();
    // Let the last words drain, then give the block time to show anything stray.
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("sliding_window_fetch_tracker_top verification clean");
    end else begin
      $display("sliding_window_fetch_tracker_top verification failed");
    end
    $finish;
  end

endmodule
